// File: hw/rtl/bptc_pkg.sv
package bptc_pkg;

  localparam int RAW_W   = 24;   // raw conversion result
  localparam int SCL_W   = 31;   // scaled reading, signed Q24
  localparam int MAG_W   = 30;   // magnitude of a scaled reading
  localparam int RECIP_W = 31;
  localparam int NUM_W   = 35;   // |raw| << shift plus half divisor
  localparam int DIV_W   = 8;
  localparam int SH_W    = 4;

  // Mulq unit operand / result widths
  localparam int MQ_AW = 56;
  localparam int MQ_BW = 40;
  localparam int MQ_PW = 64;

  // Output limits
  localparam logic signed [15:0] TEMP_MAX  = 16'sh7FFF;
  localparam logic signed [15:0] TEMP_MIN  = -16'sh8000;
  localparam logic [22:0]        PRESS_MAX = 23'h7FFFFF;
  localparam logic [22:0]        PRESS_MIN = 23'h000000;

  // Scale factor k = 2^s * d, d = 2^j - 1.
  // Reading scaled as q = floor((|r| * 2^(24-s) + (d-1)/2) / d).
  localparam logic [DIV_W-1:0] SCALE_DIV [8] = '{
    8'd1, 8'd3, 8'd7, 8'd15, 8'd31, 8'd63, 8'd127, 8'd255
  };
  localparam logic [DIV_W-1:0] SCALE_HALF [8] = '{
    8'd0, 8'd1, 8'd3, 8'd7, 8'd15, 8'd31, 8'd63, 8'd127
  };
  localparam logic [SH_W-1:0] SCALE_SHIFT [8] = '{
    4'd5, 4'd5, 4'd5, 4'd5, 4'd11, 4'd11, 4'd11, 4'd11
  };
  // floor(2^(shift+24) / d)
  localparam logic [RECIP_W-1:0] SCALE_RECIP [8] = '{
    31'((64'd1 << 29) / 64'd1),
    31'((64'd1 << 29) / 64'd3),
    31'((64'd1 << 29) / 64'd7),
    31'((64'd1 << 29) / 64'd15),
    31'((64'd1 << 35) / 64'd31),
    31'((64'd1 << 35) / 64'd63),
    31'((64'd1 << 35) / 64'd127),
    31'((64'd1 << 35) / 64'd255)
  };

  typedef enum logic [2:0] {
    REG_CAL_LO    = 3'd0,
    REG_CAL_MID   = 3'd1,
    REG_CAL_HI    = 3'd2,
    REG_PRESS_OSR = 3'd3,
    REG_TEMP_OSR  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SCL_W-1:0] ts;
    logic signed [SCL_W-1:0] ps;
  } scaled_pair_t;

  typedef struct packed {
    logic signed [11:0] c0;
    logic signed [11:0] c1;
    logic signed [19:0] c00;
    logic signed [19:0] c10;
    logic signed [15:0] c01;
    logic signed [15:0] c11;
    logic signed [15:0] c20;
    logic signed [15:0] c21;
    logic signed [15:0] c30;
  } coef_t;

endpackage

// File: hw/rtl/bptc_mulq.sv
// Q24 product, rounded half away from zero: sign * ((|a|*|b| + 2^23) >> 24).
// Five register stages.
module bptc_mulq import bptc_pkg::*; (
  input  logic                    clk,
  input  logic signed [MQ_AW-1:0] a,
  input  logic signed [MQ_BW-1:0] b,
  output logic signed [MQ_PW-1:0] p
);

  logic             neg0, neg1, neg2, neg3;
  logic [MQ_AW-1:0] ua;
  logic [MQ_BW-1:0] ub;
  logic [47:0]      p00, p01, p10, p11;
  logic [68:0]      x2, y2;
  logic [96:0]      tot;
  logic [62:0]      mag3;

  assign tot = 97'(x2) + (97'(y2) << 28);

  always_ff @(posedge clk) begin
    neg0 <= a[MQ_AW-1] ^ b[MQ_BW-1];
    ua   <= a[MQ_AW-1] ? MQ_AW'(-a) : MQ_AW'(a);
    ub   <= b[MQ_BW-1] ? MQ_BW'(-b) : MQ_BW'(b);

    neg1 <= neg0;
    p00  <= 48'(ua[27:0])  * 48'(ub[19:0]);
    p01  <= 48'(ua[27:0])  * 48'(ub[39:20]);
    p10  <= 48'(ua[55:28]) * 48'(ub[19:0]);
    p11  <= 48'(ua[55:28]) * 48'(ub[39:20]);

    neg2 <= neg1;
    x2   <= 69'(p00) + (69'(p01) << 20) + 69'(24'h800000);
    y2   <= 69'(p10) + (69'(p11) << 20);

    neg3 <= neg2;
    mag3 <= tot[86:24];

    p <= neg3 ? -$signed({1'b0, mag3}) : $signed({1'b0, mag3});
  end

endmodule

// File: hw/rtl/bptc_front.sv
// Front end: takes a reading pair and scales both readings into signed Q24.
// Reciprocal multiply, then an exact remainder correction of up to two.
module bptc_front import bptc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic signed [RAW_W-1:0] raw_temperature,
  input  logic signed [RAW_W-1:0] raw_pressure,
  input  logic [2:0]              temp_sel,
  input  logic [2:0]              press_sel,
  output logic                    push,
  output scaled_pair_t            push_data
);

  logic [7:1] vld;
  logic signed [SCL_W-1:0] lane_out [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[6:1], accept};
    end
  end

  assign push         = vld[7];
  assign push_data.ts = lane_out[0];
  assign push_data.ps = lane_out[1];

  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic [2:0]              sel;
    logic signed [RAW_W-1:0] raw1;
    logic [RAW_W-1:0]        mag2;
    logic                    neg2, neg3, neg4, neg5, neg6;
    logic [54:0]             prod3;
    logic [NUM_W-1:0]        num3, num4, num5;
    logic [MAG_W-1:0]        qe4, qe5, q6;
    logic [37:0]             qd5;
    logic [37:0]             rem;
    logic [MAG_W-1:0]        corr;

    assign sel = (g == 0) ? temp_sel : press_sel;
    assign rem = 38'(num5) - qd5;

    always_comb begin
      if (rem >= 38'({SCALE_DIV[sel], 1'b0})) begin
        corr = MAG_W'(2);
      end else if (rem >= 38'(SCALE_DIV[sel])) begin
        corr = MAG_W'(1);
      end else begin
        corr = '0;
      end
    end

    always_ff @(posedge clk) begin
      raw1  <= (g == 0) ? raw_temperature : raw_pressure;

      neg2  <= raw1[RAW_W-1];
      mag2  <= raw1[RAW_W-1] ? RAW_W'(-raw1) : RAW_W'(raw1);

      neg3  <= neg2;
      prod3 <= 55'(mag2) * 55'(SCALE_RECIP[sel]);
      num3  <= (NUM_W'(mag2) << SCALE_SHIFT[sel]) + NUM_W'(SCALE_HALF[sel]);

      neg4  <= neg3;
      qe4   <= prod3[53:24];
      num4  <= num3;

      neg5  <= neg4;
      qe5   <= qe4;
      num5  <= num4;
      qd5   <= 38'(qe4) * 38'(SCALE_DIV[sel]);

      neg6  <= neg5;
      q6    <= qe5 + corr;

      lane_out[g] <= neg6 ? -$signed({1'b0, q6}) : $signed({1'b0, q6});
    end
  end

endmodule

// File: hw/rtl/bptc_fifo.sv
// Queue between front and back. Space is reserved at accept time, so the
// front never has to stall once an item is in flight.
module bptc_fifo import bptc_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         reserve,
  input  logic         push,
  input  scaled_pair_t push_data,
  output logic         full,
  output logic         pop_valid,
  output scaled_pair_t pop_data
);

  localparam int AW = $clog2(DEPTH);

  scaled_pair_t  mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count, credits;
  logic          pop;

  assign pop  = (count != '0);
  assign full = (credits == (AW+1)'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    pop_data <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      credits   <= '0;
      pop_valid <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count     <= count + (AW+1)'(push) - (AW+1)'(pop);
      credits   <= credits + (AW+1)'(reserve) - (AW+1)'(pop);
      pop_valid <= pop;
    end
  end

endmodule

// File: hw/rtl/bptc_back.sv
// Back end: temperature and pressure polynomials, rounding and clamping.
// Slot numbers count register stages after the queue output (slot 0).
module bptc_back import bptc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  scaled_pair_t       in_data,
  input  coef_t              coef,
  output logic               done,
  output logic signed [15:0] temperature,
  output logic [22:0]        pressure,
  output logic               clipped
);

  logic [16:1] v;

  logic signed [30:0] ps_d [1:8];
  logic signed [46:0] pc30, pc21, tc01;
  logic signed [42:0] tc1;
  logic signed [46:0] i1, j1;
  logic signed [42:0] tq, tq_rnd;
  logic signed [26:0] tr_d [3:15];
  logic signed [46:0] j1_d [3:5];
  logic signed [46:0] tc01_d [2:10];
  logic signed [52:0] q2;
  logic signed [57:0] pa_d [11:13];
  logic signed [59:0] pq, pq_rnd;
  logic signed [41:0] pr;
  logic               t_hi, t_lo, p_hi, p_lo;

  logic signed [MQ_PW-1:0] tsps, m1, m2, q3;

  // ts * ps : slot 0 -> 5
  bptc_mulq u_mq_tp (
    .clk (clk),
    .a   (MQ_AW'(in_data.ts)),
    .b   (MQ_BW'(in_data.ps)),
    .p   (tsps)
  );
  // ps * i1 : slot 2 -> 7
  bptc_mulq u_mq_m1 (
    .clk (clk),
    .a   (MQ_AW'(i1)),
    .b   (MQ_BW'(ps_d[2])),
    .p   (m1)
  );
  // ps * q2 : slot 8 -> 13
  bptc_mulq u_mq_m2 (
    .clk (clk),
    .a   (MQ_AW'(q2)),
    .b   (MQ_BW'(ps_d[8])),
    .p   (m2)
  );
  // (ts*ps) * j1 : slot 5 -> 10
  bptc_mulq u_mq_q3 (
    .clk (clk),
    .a   (MQ_AW'(j1_d[5])),
    .b   (MQ_BW'($signed(tsps[35:0]))),
    .p   (q3)
  );

  assign tq_rnd = tq + (tq[42] ? 43'sd32767 : 43'sd32768);
  assign pq_rnd = pq + (pq[59] ? 60'sd131071 : 60'sd131072);

  assign t_hi = (tr_d[15] > 27'(TEMP_MAX));
  assign t_lo = (tr_d[15] < 27'(TEMP_MIN));
  assign p_hi = (pr > $signed({19'd0, PRESS_MAX}));
  assign p_lo = pr[41];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[15:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    // slot 1
    pc30 <= 47'(in_data.ps) * 47'(coef.c30);
    pc21 <= 47'(in_data.ps) * 47'(coef.c21);
    tc01 <= 47'(in_data.ts) * 47'(coef.c01);
    tc1  <= 43'(in_data.ts) * 43'(coef.c1);
    ps_d[1] <= in_data.ps;
    for (int k = 2; k <= 8; k++) begin
      ps_d[k] <= ps_d[k-1];
    end

    // slot 2
    i1 <= (47'(coef.c20) <<< 24) + pc30;
    j1 <= (47'(coef.c11) <<< 24) + pc21;
    tq <= (43'(coef.c0) <<< 23) + tc1;
    tc01_d[2] <= tc01;
    for (int k = 3; k <= 10; k++) begin
      tc01_d[k] <= tc01_d[k-1];
    end

    // slot 3..5: temperature rounding, j1 alignment
    tr_d[3] <= 27'(tq_rnd >>> 16);
    for (int k = 4; k <= 15; k++) begin
      tr_d[k] <= tr_d[k-1];
    end
    j1_d[3] <= j1;
    j1_d[4] <= j1_d[3];
    j1_d[5] <= j1_d[4];

    // slot 8
    q2 <= (53'(coef.c10) <<< 24) + $signed(m1[52:0]);

    // slot 11: everything but the ps*q2 term
    pa_d[11] <= (58'(coef.c00) <<< 24) + 58'(tc01_d[10]) + 58'($signed(q3[56:0]));
    pa_d[12] <= pa_d[11];
    pa_d[13] <= pa_d[12];

    // slot 14, 15
    pq <= 60'(pa_d[13]) + 60'($signed(m2[57:0]));
    pr <= 42'(pq_rnd >>> 18);

    // slot 16: clamp
    if (t_hi) begin
      temperature <= TEMP_MAX;
    end else if (t_lo) begin
      temperature <= TEMP_MIN;
    end else begin
      temperature <= 16'(tr_d[15]);
    end
    if (p_lo) begin
      pressure <= PRESS_MIN;
    end else if (p_hi) begin
      pressure <= PRESS_MAX;
    end else begin
      pressure <= 23'(pr);
    end
    clipped <= t_hi | t_lo | p_hi | p_lo;
  end

  assign done = v[16];

endmodule

// File: hw/rtl/baro_pressure_temp_compensation_core.sv
// Channel    | Ports                                        | Handshake
// -----------+----------------------------------------------+--------------------------
// input      | raw_temperature, raw_pressure                | start high, busy low
// result     | temperature, pressure, clipped               | done, one cycle, no stall
// config     | wr_index, wr_data                            | wr_en, no wait
//
// One transaction per cycle sustained while busy is low. Register stages from
// input to result: 7 scaling stages in the front, 2 through the queue, 16 in the
// polynomial back end (its longest path is two chained 5-stage Q24 multiply
// units). rst is synchronous and clears all control state; the calibration
// registers reset to zero, oversampling selects to 6 (pressure) and 3
// (temperature). busy rises only when the queue has no free slot reserved;
// the receiver cannot stall, so the back end drains one entry every cycle.
module baro_pressure_temp_compensation_core import bptc_pkg::*; #(
  parameter int QUEUE_DEPTH = 16   // must exceed the front's in-flight count
) (
  input  logic                    clk,
  input  logic                    rst,
  // input transactions
  input  logic                    start,
  output logic                    busy,
  input  logic signed [RAW_W-1:0] raw_temperature,
  input  logic signed [RAW_W-1:0] raw_pressure,
  // results
  output logic                    done,
  output logic signed [15:0]      temperature,
  output logic [22:0]             pressure,
  output logic                    clipped,
  // configuration
  input  logic                    wr_en,
  input  logic [2:0]              wr_index,
  input  logic [63:0]             wr_data
);

  localparam int LATENCY = 25;

  // configuration registers
  logic [63:0] cal_lo;
  logic [63:0] cal_mid;
  logic [15:0] cal_hi;
  logic [2:0]  press_osr;
  logic [2:0]  temp_osr;

  logic         accept;
  logic         push;
  scaled_pair_t push_data;
  logic         q_valid;
  scaled_pair_t q_data;
  coef_t        coef;

  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_lo    <= '0;
      cal_mid   <= '0;
      cal_hi    <= '0;
      press_osr <= 3'd6;
      temp_osr  <= 3'd3;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_CAL_LO:    cal_lo    <= wr_data;
        REG_CAL_MID:   cal_mid   <= wr_data;
        REG_CAL_HI:    cal_hi    <= wr_data[15:0];
        REG_PRESS_OSR: press_osr <= wr_data[2:0];
        REG_TEMP_OSR:  temp_osr  <= wr_data[2:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // Coefficient unpack; calibration byte 0 is the MSB of cal_lo.
  assign coef.c0  = cal_lo[63:52];
  assign coef.c1  = cal_lo[51:40];
  assign coef.c00 = cal_lo[39:20];
  assign coef.c10 = cal_lo[19:0];
  assign coef.c01 = cal_mid[63:48];
  assign coef.c11 = cal_mid[47:32];
  assign coef.c20 = cal_mid[31:16];
  assign coef.c21 = cal_mid[15:0];
  assign coef.c30 = cal_hi;

  bptc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .raw_temperature (raw_temperature),
    .raw_pressure    (raw_pressure),
    .temp_sel        (temp_osr),
    .press_sel       (press_osr),
    .push            (push),
    .push_data       (push_data)
  );

  bptc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .reserve   (accept),
    .push      (push),
    .push_data (push_data),
    .full      (busy),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  bptc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_valid),
    .in_data     (q_data),
    .coef        (coef),
    .done        (done),
    .temperature (temperature),
    .pressure    (pressure),
    .clipped     (clipped)
  );

  // Fixed latency: the back end never stalls, so every accepted
  // transaction comes out a constant number of cycles later.
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("result missing at fixed latency");

  // An in-range result must not be flagged.
  a_clip_only_at_limit: assert property (@(posedge clk) disable iff (rst)
    (done && temperature != TEMP_MAX && temperature != TEMP_MIN &&
     pressure != PRESS_MAX && pressure != PRESS_MIN) |-> !clipped)
    else $error("clipped set on unsaturated result");

endmodule

// File: bench/baro_pressure_temp_compensation_core_tb.sv
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_core_tb;
  import bptc_pkg::*;

  localparam int PIPE_LAT = 25;
  // Index past the last register; the block must ignore writes to it.
  localparam logic [2:0] REG_NONE = 3'd7;
  localparam longint unsigned OSR_SCALE [8] = '{
    524288, 1572864, 3670016, 7864320, 253952, 516096, 1040384, 2088960
  };

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_t;
    logic signed [RAW_W-1:0] raw_p;
  } reading_t;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [22:0]        press;
    logic               clip;
  } comp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [RAW_W-1:0] raw_temperature = '0;
  logic signed [RAW_W-1:0] raw_pressure = '0;
  logic done;
  logic signed [15:0] temperature;
  logic [22:0] pressure;
  logic clipped;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = REG_CAL_LO;
  logic [63:0] wr_data = '0;

  // Shadow copy of the block's configuration registers.
  logic [63:0] cal_lo = '0;
  logic [63:0] cal_mid = '0;
  logic [15:0] cal_hi = '0;
  logic [2:0] p_osr = 3'd6;
  logic [2:0] t_osr = 3'd3;

  reading_t readings_q[$];   // readings waiting to be sent
  comp_t    comp_q[$];       // compensated results in flight
  int       fail_cnt = 0;
  int       gap_left = 0;

  always #10 clk = ~clk;

  baro_pressure_temp_compensation_core u_top (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
    .done(done), .temperature(temperature), .pressure(pressure), .clipped(clipped),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned abs64(longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  function automatic longint signed_of(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // Q24 x Q24 with full-width product, rounded half away from zero.
  function automatic longint q24_mul(longint a, longint b);
    logic [127:0] prod;
    prod = 128'(abs64(a)) * 128'(abs64(b));
    prod = (prod + 128'h800000) >> 24;
    return signed_of(prod[63:0], (a < 0) != (b < 0));
  endfunction

  function automatic longint round_shift(longint x, int s);
    return signed_of((abs64(x) + (64'd1 << (s - 1))) >> s, x < 0);
  endfunction

  // Raw reading divided by its oversampling scale factor, Q24.
  function automatic longint scale_raw(logic signed [RAW_W-1:0] raw, logic [2:0] sel);
    longint r;
    longint unsigned k;
    r = longint'(raw);
    k = OSR_SCALE[sel];
    return signed_of(((abs64(r) << 24) + k / 2) / k, r < 0);
  endfunction

  function automatic comp_t compensate(reading_t rd);
    longint one, c0, c1, c00, c10, c01, c11, c20, c21, c30;
    longint ts, ps, tq, t, i1, q2, j1, q3, pq, p;
    comp_t res;
    one = 64'd16777216;
    c0  = longint'($signed(cal_lo[63:52]));
    c1  = longint'($signed(cal_lo[51:40]));
    c00 = longint'($signed(cal_lo[39:20]));
    c10 = longint'($signed(cal_lo[19:0]));
    c01 = longint'($signed(cal_mid[63:48]));
    c11 = longint'($signed(cal_mid[47:32]));
    c20 = longint'($signed(cal_mid[31:16]));
    c21 = longint'($signed(cal_mid[15:0]));
    c30 = longint'($signed(cal_hi[15:0]));
    ts = scale_raw(rd.raw_t, t_osr);
    ps = scale_raw(rd.raw_p, p_osr);
    tq = c0 * 8388608 + ts * c1;
    t  = round_shift(tq, 16);
    i1 = c20 * one + q24_mul(ps, c30 * one);
    q2 = c10 * one + q24_mul(ps, i1);
    j1 = c11 * one + q24_mul(ps, c21 * one);
    q3 = q24_mul(q24_mul(ts, ps), j1);
    pq = c00 * one + q24_mul(ps, q2) + q24_mul(ts, c01 * one) + q3;
    p  = round_shift(pq, 18);
    res.clip = 1'b0;
    if (t > 32767) begin t = 32767; res.clip = 1'b1; end
    if (t < -32768) begin t = -32768; res.clip = 1'b1; end
    if (p > 8388607) begin p = 8388607; res.clip = 1'b1; end
    if (p < 0) begin p = 0; res.clip = 1'b1; end
    res.temp = t[15:0];
    res.press = p[22:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- driver
  // One transaction launched from the pending queue whenever the random gap
  // has run out. start stays high until the block takes the reading; the
  // expected result is computed at the accepting edge.
  always @(posedge clk) begin
    reading_t nxt;
    logic     go;
    int       roll;
    go = start;
    if (rst) begin
      go = 1'b0;
    end else begin
      if (start && !busy) begin
        comp_q.push_back(compensate('{raw_temperature, raw_pressure}));
        go = 1'b0;
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (readings_q.size() > 0) begin
          nxt = readings_q.pop_front();
          raw_temperature <= nxt.raw_t;
          raw_pressure <= nxt.raw_p;
          go = 1'b1;
          roll = $urandom_range(99);
          // mostly back to back, some short gaps, a few long ones
          gap_left = roll < 60 ? 0 : roll < 93 ? $urandom_range(3, 1) : $urandom_range(40, 8);
        end
      end
    end
    start <= go;
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    comp_t exp_r;
    if (!rst && done) begin
      if (comp_q.size() == 0) begin
        $error("result with no transaction outstanding");
        fail_cnt++;
      end else begin
        exp_r = comp_q.pop_front();
        if (temperature !== exp_r.temp) begin
          $error("temperature: expected %0d, got %0d", exp_r.temp, temperature);
          fail_cnt++;
        end
        if (pressure !== exp_r.press) begin
          $error("pressure: expected %0d, got %0d", exp_r.press, pressure);
          fail_cnt++;
        end
        if (clipped !== exp_r.clip) begin
          $error("clipped: expected %0b, got %0b", exp_r.clip, clipped);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    case (idx)
      REG_CAL_LO:    cal_lo = val;
      REG_CAL_MID:   cal_mid = val;
      REG_CAL_HI:    cal_hi = val[15:0];
      REG_PRESS_OSR: p_osr = val[2:0];
      REG_TEMP_OSR:  t_osr = val[2:0];
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // Sender holds off until every reading is accepted and every result is in.
  task automatic drain();
    while (readings_q.size() > 0 || start || comp_q.size() > 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  task automatic add_reading(logic [RAW_W-1:0] rt, logic [RAW_W-1:0] rp);
    readings_q.push_back('{rt, rp});
  endtask

  // Random reading: mostly full range, some near zero, some at the rails.
  task automatic add_random(int n);
    int roll;
    logic [RAW_W-1:0] rt, rp;
    repeat (n) begin
      roll = $urandom_range(9);
      rt = $urandom;
      rp = $urandom;
      if (roll < 3) begin
        rt = $signed(RAW_W'($urandom_range(8000))) - 4000;
        rp = $signed(RAW_W'($urandom_range(600000))) - 300000;
      end else if (roll == 9) begin
        rt = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
        rp = $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
      end
      add_reading(rt, rp);
    end
  endtask

  task automatic load_cal(logic [63:0] lo, logic [63:0] mid, logic [63:0] hi,
                          logic [63:0] posr, logic [63:0] tosr);
    reg_write(REG_CAL_LO, lo);
    reg_write(REG_CAL_MID, mid);
    reg_write(REG_CAL_HI, hi);
    reg_write(REG_PRESS_OSR, posr);
    reg_write(REG_TEMP_OSR, tosr);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: all coefficients zero, default oversampling.
    add_reading(24'h000000, 24'h000000);
    add_reading(24'h7FFFFF, 24'h800000);
    drain();

    // Typical calibration: c0=200 c1=-260 c00=80000 c10=-50000 c01=-3000
    // c11=1000 c20=-10000 c21=100 c30=-1000.
    load_cal({12'd200, 12'hEFC, 20'd80000, 20'hF3CB0},
             {16'hF448, 16'd1000, 16'hD8F0, 16'd100},
             {48'hDEAD_BEEF_0000, 16'hFC18}, 64'd6, 64'd3);
    add_reading(24'h000000, 24'h000000);
    add_reading(24'h7FFFFF, 24'h7FFFFF);
    add_reading(24'h800000, 24'h800000);
    add_reading(24'h7FFFFF, 24'h800000);
    add_reading(24'h800000, 24'h7FFFFF);
    add_reading(24'hFFFFFF, 24'h000001);
    add_reading(24'h000001, 24'hFFFFFF);
    add_reading(24'hFFF000, 24'hFD0000);  // realistic: normal pressure output
    add_reading(24'h002000, 24'h400000);  // drives pressure negative
    drain();

    // Extremes of the oversampling index plus an ignored register index.
    reg_write(REG_NONE, '1);
    reg_write(REG_PRESS_OSR, 64'hFFFF_FFFF_FFFF_FFF8);   // upper bits ignored
    reg_write(REG_TEMP_OSR, 64'd7);
    add_reading(24'h7FFFFF, 24'h7FFFFF);
    add_reading(24'h800000, 24'h800000);
    add_reading(24'h0ABCDE, 24'hF54321);
    drain();

    // All coefficient bytes 0xFF and 0x80-patterned, widest scale settings.
    load_cal('1, '1, '1, 64'd7, 64'd0);
    add_reading(24'h7FFFFF, 24'h7FFFFF);
    add_reading(24'h800000, 24'h800000);
    add_reading(24'h000000, 24'h7FFFFF);
    drain();
    load_cal(64'h8008_0000_8000_0080, 64'h8000_8000_8000_8000, 64'h8000, 64'd0, 64'd4);
    add_reading(24'h7FFFFF, 24'h800000);
    add_reading(24'h800000, 24'h7FFFFF);
    add_reading(24'h000001, 24'hFFFFFF);
    drain();
    load_cal(64'h7FF7_FF7F_FFF7_FFFF, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF, 64'd4, 64'd7);
    add_reading(24'h7FFFFF, 24'h7FFFFF);
    add_reading(24'h800000, 24'h800000);
    drain();

    // Random phases: every third one uses a typical-looking calibration, the rest arbitrary.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 0)
        load_cal({12'(190 + $urandom_range(40)), 12'hEFC, 20'(70000 + $urandom_range(20000)),
                  20'hF3CB0 + 20'($urandom_range(4000))},
                 {16'hF448, 16'(900 + $urandom_range(200)), 16'hD8F0, 16'($urandom_range(200))},
                 {$urandom, 16'hFC18 + 16'($urandom_range(100)), 16'hFFFF},
                 $urandom_range(7), $urandom_range(7));
      else
        load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
      add_random(100);
      // hold the sender off once mid-phase until every result is back
      if (ph == 4) begin
        drain();
        add_random(10);
      end
      drain();
    end

    if (fail_cnt == 0) begin
      $display("baro_pressure_temp_compensation_core regression: pass");
    end else begin
      $display("baro_pressure_temp_compensation_core regression: fail");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("baro_pressure_temp_compensation_core regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bptc_pkg.sv
hw/rtl/bptc_mulq.sv
hw/rtl/bptc_front.sv
hw/rtl/bptc_fifo.sv
hw/rtl/bptc_back.sv
hw/rtl/baro_pressure_temp_compensation_core.sv
bench/baro_pressure_temp_compensation_core_tb.sv
